// File: design/dbs_pkg.sv
// Shared constants, op and status codes and cell control type for the deque store.
package dbs_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_REMOVE     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cell update selection; at most one bit is set.
    typedef struct packed {
        logic load;       // take the pushed value
        logic from_left;  // take the front-side neighbour
        logic from_right; // take the back-side neighbour
    } t_cell_ctl;

endpackage

// File: design/dbs_cell.sv
// One storage cell of the chain: holds an entry, compares it, shifts either way.
module dbs_cell
    import dbs_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_occupied,
    input  logic [VAL_W-1:0] i_key,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_value,
    output logic             o_match
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;

    // next entry: pushed value, neighbour, or hold
    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_key;
        end else if (i_ctl.from_left) begin
            n_value = i_left;
        end else if (i_ctl.from_right) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // only live entries may match
    assign o_match = i_occupied && (r_value == i_key);
    assign o_value = r_value;

endmodule

// File: design/dbs_first_match.sv
// Inclusive prefix OR of the cell match bits: marks the first match and all cells behind it.
module dbs_first_match
    import dbs_pkg::*;
(
    input  logic [DEPTH-1:0] i_match,
    output logic [DEPTH-1:0] o_at_or_after
);

    localparam int LEVELS = $clog2(DEPTH);

    logic [DEPTH-1:0] w_lvl [0:LEVELS];

    assign w_lvl[0] = i_match;

    // log-depth scan, span doubles each level
    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
        for (genvar i = 0; i < DEPTH; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign w_lvl[k+1][i] = w_lvl[k][i] | w_lvl[k][i-(1<<k)];
            end else begin : g_pass
                assign w_lvl[k+1][i] = w_lvl[k][i];
            end
        end
    end

    assign o_at_or_after = w_lvl[LEVELS];

endmodule

// File: design/deque_bag_store.sv
// Top level of the bounded double-ended queue / bag built from a chain of shifting cells.
//
//  channel | direction | handshake                  | beat payload
//  --------+-----------+----------------------------+---------------------------------------
//  command | in        | start, busy                | i_op, i_item_value
//  result  | out       | o_result_valid (strobe)    | o_front_value, o_back_value,
//          |           |                            | o_entry_count, o_found, o_status
//
// A command beat updates every cell at once at the accepting edge; the next cycle
// registers the front and back values (back is an AND-OR select over the cells),
// with busy high. The result strobe follows, so one command takes two cycles and a
// new command may be taken in the strobe cycle. The receiver cannot stall: each
// result is shown for exactly one cycle. Synchronous reset empties the store; the
// cell contents are not cleared and are never read while unoccupied.
module deque_bag_store
    import dbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_op,
    input  logic [VAL_W-1:0] i_item_value,
    output logic             o_result_valid,
    output logic [VAL_W-1:0] o_front_value,
    output logic [VAL_W-1:0] o_back_value,
    output logic [4:0]       o_entry_count,
    output logic             o_found,
    output logic [1:0]       o_status
);

    logic             w_accept;
    t_op              w_op;
    logic             w_full;
    logic             w_empty;
    logic             w_any_match;
    logic             w_push_ok;
    logic             w_shrink;

    logic [DEPTH-1:0] w_occ;
    logic [DEPTH-1:0] w_last;
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_tail;
    t_cell_ctl        w_ctl   [DEPTH];
    logic [VAL_W-1:0] w_value [DEPTH];
    logic [VAL_W-1:0] w_left  [DEPTH];
    logic [VAL_W-1:0] w_right [DEPTH];
    logic [VAL_W-1:0] w_back_sel;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_found;
    logic             n_found;
    t_status          r_status;
    t_status          n_status;
    logic             r_calc;
    logic             r_strobe;
    logic [VAL_W-1:0] r_front;
    logic [VAL_W-1:0] r_back;
    logic [CNT_W+4:0] w_cnt_ext;

    assign w_accept = start && !busy;
    assign w_op     = t_op'(i_op);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    // occupancy and back-position flags per cell
    for (genvar i = 0; i < DEPTH; i++) begin : g_flags
        assign w_occ[i]  = (CNT_W'(i) < r_count);
        assign w_last[i] = (CNT_W'(i + 1) == r_count);
    end

    dbs_first_match u_first_match (
        .i_match       (w_match),
        .o_at_or_after (w_tail)
    );

    assign w_any_match = w_tail[DEPTH-1];

    // per-cell shift and load control
    for (genvar i = 0; i < DEPTH; i++) begin : g_ctl
        always_comb begin
            w_ctl[i] = '0;
            if (w_accept) begin
                case (w_op)
                    OP_PUSH_FRONT: begin
                        if (!w_full) begin
                            w_ctl[i].load      = (i == 0);
                            w_ctl[i].from_left = (i != 0);
                        end
                    end
                    OP_PUSH_BACK: begin
                        w_ctl[i].load = !w_full && (CNT_W'(i) == r_count);
                    end
                    OP_POP_FRONT: begin
                        w_ctl[i].from_right = !w_empty;
                    end
                    OP_REMOVE: begin
                        w_ctl[i].from_right = w_tail[i];
                    end
                    default: begin
                        w_ctl[i] = '0;
                    end
                endcase
            end
        end
    end

    // the cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_left[i] = i_item_value;
        end else begin : g_mid_l
            assign w_left[i] = w_value[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign w_right[i] = '0;
        end else begin : g_mid_r
            assign w_right[i] = w_value[i+1];
        end

        dbs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[i]),
            .i_occupied (w_occ[i]),
            .i_key      (i_item_value),
            .i_left     (w_left[i]),
            .i_right    (w_right[i]),
            .o_value    (w_value[i]),
            .o_match    (w_match[i])
        );
    end

    // count, found and status for the accepted command
    assign w_push_ok = ((w_op == OP_PUSH_FRONT) || (w_op == OP_PUSH_BACK)) && !w_full;
    assign w_shrink  = (((w_op == OP_POP_FRONT) || (w_op == OP_POP_BACK)) && !w_empty)
                    || ((w_op == OP_REMOVE) && w_any_match);

    always_comb begin
        n_count  = r_count;
        n_found  = 1'b0;
        n_status = ST_OK;
        if (w_push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_shrink) begin
            n_count = r_count - CNT_W'(1);
        end
        case (w_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                n_status = w_full ? ST_FULL : ST_OK;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                n_status = w_empty ? ST_EMPTY : ST_OK;
            end
            OP_CONTAINS: begin
                n_found = w_any_match;
            end
            OP_REMOVE: begin
                n_status = w_empty ? ST_EMPTY : ST_OK;
                n_found  = w_any_match;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // back entry select over the chain
    always_comb begin
        w_back_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_sel = w_back_sel | (w_value[i] & {VAL_W{w_last[i]}});
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_calc   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_calc   <= w_accept;
            r_strobe <= r_calc;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found  <= n_found;
            r_status <= n_status;
        end
        if (r_calc) begin
            r_front <= w_empty ? '0 : w_value[0];
            r_back  <= w_back_sel;
        end
    end

    assign busy           = r_calc;
    assign w_cnt_ext      = {5'b0, r_count};
    assign o_result_valid = r_strobe;
    assign o_front_value  = r_front;
    assign o_back_value   = r_back;
    assign o_entry_count  = w_cnt_ext[4:0];
    assign o_found        = r_found;
    assign o_status       = r_status;

    // a result always follows the busy cycle of its command
    a_strobe_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // the count never passes the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // a dropped push is only reported on a full store
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_FULL)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status on a store that is not full");

    // an empty store reports zero at both ends
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (r_count == '0)) |-> ((o_front_value == '0) && (o_back_value == '0)))
        else $error("non-zero end value on an empty store");

endmodule

// File: test/tb_deque_bag_store.sv
// Self-checking testbench for the deque / bag store: directed corner cases, then random traffic.
`timescale 1ns / 1ps

module tb_deque_bag_store
    import dbs_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 500;
    localparam int          BEATS_PER_PHASE = 440;
    localparam logic [2:0]  OP_SPARE_6 = 3'd6;
    localparam logic [2:0]  OP_SPARE_7 = 3'd7;

    // Bias of the random op mix
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct {
        logic [VAL_W-1:0] front_value;
        logic [VAL_W-1:0] back_value;
        logic [4:0]       entry_count;
        logic             found;
        t_status          status;
    } t_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       i_op;
    logic [VAL_W-1:0] i_item_value;
    logic             o_result_valid;
    logic [VAL_W-1:0] o_front_value;
    logic [VAL_W-1:0] o_back_value;
    logic [4:0]       o_entry_count;
    logic             o_found;
    logic [1:0]       o_status;

    logic [VAL_W-1:0] deque_shadow[$];      // front at index 0
    t_outcome         expected_outcomes[$];
    int               mismatch_count = 0;
    int               idle_cycles = 0;
    int               sender_idle_pct = 0;

    // Small pool so that searches and removals hit often
    logic [VAL_W-1:0] value_pool[8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                                        32'hAAAA_AAAA, 32'h0000_0005};

    deque_bag_store i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_item_value   (i_item_value),
        .o_result_valid (o_result_valid),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_entry_count  (o_entry_count),
        .o_found        (o_found),
        .o_status       (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Apply one operation to the shadow deque and work out the reported outcome
    function automatic t_outcome predict_outcome(input logic [2:0] op,
                                                 input logic [VAL_W-1:0] value);
        t_outcome res;
        int       hit;
        res.found  = 1'b0;
        res.status = ST_OK;
        hit        = -1;
        case (op)
            OP_PUSH_FRONT: begin
                if (deque_shadow.size() >= DEPTH) res.status = ST_FULL;
                else deque_shadow.push_front(value);
            end
            OP_PUSH_BACK: begin
                if (deque_shadow.size() >= DEPTH) res.status = ST_FULL;
                else deque_shadow.push_back(value);
            end
            OP_POP_FRONT: begin
                if (deque_shadow.size() == 0) res.status = ST_EMPTY;
                else void'(deque_shadow.pop_front());
            end
            OP_POP_BACK: begin
                if (deque_shadow.size() == 0) res.status = ST_EMPTY;
                else void'(deque_shadow.pop_back());
            end
            OP_CONTAINS, OP_REMOVE: begin
                for (int k = 0; k < deque_shadow.size(); k++) begin
                    if (hit < 0 && deque_shadow[k] == value) hit = k;
                end
                if (op == OP_CONTAINS) begin
                    res.found = (hit >= 0);
                end else if (deque_shadow.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit >= 0) begin
                    deque_shadow.delete(hit);
                    res.found = 1'b1;
                end
            end
            default: ;  // spare codes leave the store alone
        endcase
        if (deque_shadow.size() == 0) begin
            res.front_value = '0;
            res.back_value  = '0;
        end else begin
            res.front_value = deque_shadow[0];
            res.back_value  = deque_shadow[deque_shadow.size() - 1];
        end
        res.entry_count = 5'(deque_shadow.size());
        return res;
    endfunction

    // Offer one command beat, wait for it to be taken, then maybe idle
    task automatic send_command(input logic [2:0] op, input logic [VAL_W-1:0] value);
        int gap;
        start        <= 1'b1;
        i_op         <= op;
        i_item_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_outcomes.push_back(predict_outcome(op, value));
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and let every outstanding result come back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_refusals();
        send_command(OP_POP_FRONT, 32'h1234_5678);
        send_command(OP_POP_BACK, 32'h0);
        send_command(OP_REMOVE, 32'h0);
        send_command(OP_CONTAINS, 32'h0);
        drain_results();
    endtask

    // Fill to the brim with duplicates, then push past full and try the spare codes
    task automatic test_fill_and_overflow();
        for (int k = 0; k < DEPTH; k++) begin
            send_command((k % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, value_pool[k % 8]);
        end
        send_command(OP_PUSH_FRONT, 32'hDEAD_BEEF);
        send_command(OP_PUSH_BACK, 32'hDEAD_BEEF);
        send_command(OP_SPARE_6, 32'hFFFF_FFFF);
        send_command(OP_SPARE_7, 32'h7FFF_FFFF);
        drain_results();
    endtask

    task automatic test_search_and_remove();
        send_command(OP_CONTAINS, 32'h0000_0005);
        send_command(OP_CONTAINS, 32'h0001_E240);
        send_command(OP_REMOVE, 32'h0001_E240);
        send_command(OP_REMOVE, 32'h0000_0005);   // duplicate: only the front-most goes
        send_command(OP_POP_FRONT, 32'h0);
        send_command(OP_POP_BACK, 32'h0);
        drain_results();
    endtask

    function automatic logic [2:0] pick_op(input t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 35)      return OP_PUSH_FRONT;
                else if (r < 70) return OP_PUSH_BACK;
                else if (r < 78) return OP_POP_FRONT;
                else if (r < 86) return OP_POP_BACK;
                else if (r < 92) return OP_CONTAINS;
                else if (r < 98) return OP_REMOVE;
            end
            MIX_DRAIN: begin
                if (r < 10)      return OP_PUSH_FRONT;
                else if (r < 20) return OP_PUSH_BACK;
                else if (r < 40) return OP_POP_FRONT;
                else if (r < 60) return OP_POP_BACK;
                else if (r < 70) return OP_CONTAINS;
                else if (r < 98) return OP_REMOVE;
            end
            default: begin
                if (r < 15)      return OP_PUSH_FRONT;
                else if (r < 30) return OP_PUSH_BACK;
                else if (r < 45) return OP_POP_FRONT;
                else if (r < 60) return OP_POP_BACK;
                else if (r < 78) return OP_CONTAINS;
                else if (r < 96) return OP_REMOVE;
            end
        endcase
        return r[0] ? OP_SPARE_7 : OP_SPARE_6;
    endfunction

    // Random traffic in stretches that fill, drain or churn the store
    task automatic test_random_traffic(input int idle_pct, input int beats);
        t_mix             mix;
        logic [VAL_W-1:0] value;
        sender_idle_pct = idle_pct;
        for (int k = 0; k < beats; k++) begin
            mix   = t_mix'((k / 40) % 3);
            value = ($urandom_range(99) < 65) ? value_pool[$urandom_range(7)] : $urandom;
            send_command(pick_op(mix), value);
        end
        drain_results();
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_front_value !== want.front_value) begin
                    $error("front_value: expected %h, got %h", want.front_value, o_front_value);
                    mismatch_count++;
                end
                if (o_back_value !== want.back_value) begin
                    $error("back_value: expected %h, got %h", want.back_value, o_back_value);
                    mismatch_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, o_entry_count);
                    mismatch_count++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, o_found);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles with neither a command nor a result beat
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_PUSH_FRONT;
        i_item_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_refusals();
        test_fill_and_overflow();
        test_search_and_remove();
        test_random_traffic(0, BEATS_PER_PHASE);
        test_random_traffic(63, BEATS_PER_PHASE);
        test_random_traffic(11, BEATS_PER_PHASE);

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
